FILE: rtl/downmix_envelope_follower_unit_macros.svh
// Assertion macros used by the downmix envelope follower top level.
`ifndef DOWNMIX_ENVELOPE_FOLLOWER_UNIT_MACROS_SVH
`define DOWNMIX_ENVELOPE_FOLLOWER_UNIT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define DMEF_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("dmef assertion failed");

// The condition must hold in the cycle after the trigger.
`define DMEF_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("dmef assertion failed");

`endif

FILE: rtl/dmef_pkg.sv
// Package with types, constants and tables of the downmix envelope follower.
package dmef_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int CH_BITS          = 4;
  localparam int LEN_BITS         = 17;
  localparam int VOL_BITS         = 16;
  localparam int SERIAL_BITS      = 32;
  localparam int PHASE_BITS       = 4;
  localparam int STEP_BITS        = 4;
  localparam int RECIP_SHIFT      = 18;
  localparam int RECIP_BITS       = 19;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 16;
  localparam int OUT_DATA_BITS    = 64;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [PHASE_BITS-1:0] PHASE_LAST = 4'd9;
  localparam logic [STEP_BITS-1:0]  STEP_LAST  = 4'd15;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_FRAMES    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_REMAINDER = 2'd2;

  localparam logic [CH_BITS-1:0]  CHANNEL_COUNT_RST    = 4'd2;
  localparam logic [15:0]         WINDOW_FRAMES_RST    = 16'd441;
  localparam logic [15:0]         WINDOW_REMAINDER_RST = 16'd0;

  typedef struct packed {
    logic [CH_BITS-1:0] channel_count;
    logic [15:0]        window_frames;
    logic [15:0]        window_remainder;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mixed;
    logic                   eof;
  } mix_item_t;

  // ceil(2^18 / c): exact floor division for magnitudes up to 2^15.
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CH_BITS-1:0] c);
    logic [RECIP_BITS-1:0] r;
    case (c)
      4'd1:    r = 19'd262144;
      4'd2:    r = 19'd131072;
      4'd3:    r = 19'd87382;
      4'd4:    r = 19'd65536;
      4'd5:    r = 19'd52429;
      4'd6:    r = 19'd43691;
      4'd7:    r = 19'd37450;
      4'd8:    r = 19'd32768;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/dmef_front.sv
// Front end: accepts frames and downmixes them one channel per cycle.
module dmef_front #(
  parameter int MAX_CHANNELS = dmef_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [dmef_pkg::CH_BITS-1:0]              channel_count,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [MAX_CHANNELS*dmef_pkg::SAMPLE_BITS-1:0] s_tdata,
  input  logic                                      s_tlast,
  output logic                                      push_valid,
  input  logic                                      push_ready,
  output dmef_pkg::mix_item_t                       push_item
);
  import dmef_pkg::*;

  localparam int IDX_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MIX  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t                   state;
  logic [SAMPLE_BITS-1:0]         samples [MAX_CHANNELS];
  logic                           eof;
  logic [CH_BITS-1:0]             idx;
  logic signed [SAMPLE_BITS:0]    sum;
  logic [CH_BITS-1:0]             chan_eff;
  logic [SAMPLE_BITS-1:0]         cur;
  logic [SAMPLE_BITS-1:0]         mag;
  logic [SAMPLE_BITS+RECIP_BITS-1:0] prod;
  logic [SAMPLE_BITS-1:0]         quo;
  logic signed [SAMPLE_BITS:0]    term;

  always_comb begin
    if (channel_count == '0) begin
      chan_eff = CH_BITS'(1);
    end else if (channel_count > CH_BITS'(MAX_CHANNELS)) begin
      chan_eff = CH_BITS'(MAX_CHANNELS);
    end else begin
      chan_eff = channel_count;
    end
  end

  // Truncating division: divide the magnitude, then restore the sign.
  always_comb begin
    cur  = samples[idx[IDX_BITS-1:0]];
    mag  = cur[SAMPLE_BITS-1] ? (~cur + 1'b1) : cur;
    prod = (SAMPLE_BITS+RECIP_BITS)'(mag) * (SAMPLE_BITS+RECIP_BITS)'(recip(chan_eff));
    quo  = prod[RECIP_SHIFT+SAMPLE_BITS-1:RECIP_SHIFT];
    term = cur[SAMPLE_BITS-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
              samples[k] <= s_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
            end
            eof   <= s_tlast;
            sum   <= '0;
            idx   <= '0;
            state <= F_MIX;
          end
        end
        F_MIX: begin
          sum <= sum + term;
          idx <= idx + 1'b1;
          if (idx == chan_eff - 1'b1) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign s_tready        = (state == F_IDLE);
  assign push_valid      = (state == F_PUSH);
  assign push_item.mixed = sum[SAMPLE_BITS-1:0];
  assign push_item.eof   = eof;

endmodule

FILE: rtl/dmef_queue.sv
// Short queue of downmixed frames between the front and back ends.
module dmef_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  dmef_pkg::mix_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output dmef_pkg::mix_item_t pop_item
);
  import dmef_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  mix_item_t           entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (PTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/dmef_back.sv
// Back end: envelope window bookkeeping with a bit-serial level divider.
module dmef_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dmef_pkg::cfg_t                       cfg,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  dmef_pkg::mix_item_t                  pop_item,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [dmef_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  output logic                                 m_tuser
);
  import dmef_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

  back_state_t             state;
  logic                    eof_seen;
  logic [LEN_BITS-1:0]     frames_in_window;
  logic [VOL_BITS-1:0]     volume_sum;
  logic [PHASE_BITS-1:0]   window_phase;
  logic [SERIAL_BITS-1:0]  window_serial;

  logic [SAMPLE_BITS-1:0]  cur_mixed;
  logic [LEN_BITS-1:0]     cur_len;
  logic [SAMPLE_BITS-1:0]  dividend;
  logic [LEN_BITS-1:0]     rem;
  logic [VOL_BITS-1:0]     quo;
  logic [STEP_BITS-1:0]    step;

  logic [LEN_BITS-1:0]     len_next;
  logic [LEN_BITS:0]       rem_sh;
  logic                    fits;
  logic [VOL_BITS-1:0]     level_q;
  logic [VOL_BITS-1:0]     vol_next;
  logic [LEN_BITS-1:0]     frames_next;
  logic                    window_done;
  logic [SERIAL_BITS-1:0]  number;
  logic                    out_free;

  always_comb begin
    len_next = {1'b0, cfg.window_frames};
    if (window_phase != '0) begin
      len_next = len_next + {1'b0, cfg.window_remainder};
    end
    rem_sh      = {rem, dividend[SAMPLE_BITS-1]};
    fits        = (rem_sh >= {1'b0, cur_len});
    level_q     = (cur_len == '0) ? '0 : quo;
    vol_next    = volume_sum + level_q;
    frames_next = frames_in_window + 1'b1;
    window_done = eof_seen || (frames_next == cur_len);
    number      = eof_seen ? (SERIAL_BITS'(0) - window_serial) : window_serial;
    out_free    = !m_tvalid || m_tready;
  end

  assign pop_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= B_IDLE;
      eof_seen         <= 1'b0;
      frames_in_window <= '0;
      volume_sum       <= '0;
      window_phase     <= '0;
      window_serial    <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if ((state == B_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            eof_seen  <= eof_seen | pop_item.eof;
            cur_mixed <= pop_item.mixed;
            cur_len   <= len_next;
            dividend  <= pop_item.mixed[SAMPLE_BITS-1] ? (~pop_item.mixed + 1'b1)
                                                       : pop_item.mixed;
            rem       <= '0;
            step      <= '0;
            state     <= B_DIV;
          end
        end
        B_DIV: begin
          // One restoring step per cycle; a zero length is masked at the end.
          rem      <= fits ? LEN_BITS'(rem_sh - {1'b0, cur_len}) : rem_sh[LEN_BITS-1:0];
          quo      <= {quo[VOL_BITS-2:0], fits};
          dividend <= {dividend[SAMPLE_BITS-2:0], 1'b0};
          step     <= step + 1'b1;
          if (step == STEP_LAST) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            m_tdata[SAMPLE_BITS-1:0] <= cur_mixed;
            if (window_done) begin
              m_tuser          <= 1'b1;
              m_tdata[47:16]   <= number;
              m_tdata[63:48]   <= vol_next;
              window_serial    <= window_serial + 1'b1;
              window_phase     <= (window_phase == PHASE_LAST) ? '0 : window_phase + 1'b1;
              volume_sum       <= '0;
              frames_in_window <= '0;
            end else begin
              m_tuser          <= 1'b0;
              m_tdata[47:16]   <= '0;
              m_tdata[63:48]   <= '0;
              volume_sum       <= vol_next;
              frames_in_window <= frames_next;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/downmix_envelope_follower_unit.sv
// Top level of the downmix envelope follower: config registers and wiring.
//
//   Channel   Direction  Handshake           Payload
//   s_*       in         s_tvalid/s_tready   s_tdata samples, s_tlast end of stream
//   m_*       out        m_tvalid/m_tready   m_tdata mix/number/volume, m_tuser window flag
//   cfg_*     in         cfg_we              cfg_index, cfg_data
//
// The front end mixes a frame channel by channel and takes no new frame until it has
// pushed the last; the back end runs each frame through the bit-serial level divider,
// which sets the sustained frame rate, and takes no new frame until the last result is
// registered. Reset is synchronous; there is no clearing pass. A two-entry queue lets the
// front keep mixing while the back end or the output stalls, and the output register lets
// the back end take in and divide a frame while the previous result waits.
`include "downmix_envelope_follower_unit_macros.svh"

module downmix_envelope_follower_unit #(
  parameter int MAX_CHANNELS = dmef_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // sample_0 .. sample_N-1, 16 bits each, from the lowest bit up
  input  logic [MAX_CHANNELS*dmef_pkg::SAMPLE_BITS-1:0] s_tdata,
  input  logic                                          s_tlast,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // mixed_sample [15:0], window_number [47:16], window_volume [63:48]
  output logic [dmef_pkg::OUT_DATA_BITS-1:0]            m_tdata,
  // window_valid [0]
  output logic                                          m_tuser,
  input  logic                                          cfg_we,
  input  logic [dmef_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
  input  logic [dmef_pkg::CFG_DATA_BITS-1:0]            cfg_data
);
  import dmef_pkg::*;

  cfg_t      cfg;
  logic      push_valid;
  logic      push_ready;
  mix_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  mix_item_t pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count    <= CHANNEL_COUNT_RST;
      cfg.window_frames    <= WINDOW_FRAMES_RST;
      cfg.window_remainder <= WINDOW_REMAINDER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT:    cfg.channel_count    <= cfg_data[CH_BITS-1:0];
        REG_WINDOW_FRAMES:    cfg.window_frames    <= cfg_data;
        REG_WINDOW_REMAINDER: cfg.window_remainder <= cfg_data;
        default: ;
      endcase
    end
  end

  dmef_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .channel_count(cfg.channel_count),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  dmef_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  dmef_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_item (pop_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A frame transfer keeps the front busy for at least the next cycle.
  `DMEF_ASSERT_NEXT(a_front_busy, s_tvalid && s_tready, !s_tready)
  // Results without a finished window carry no window number or volume.
  `DMEF_ASSERT_NOW(a_no_window_zero, m_tvalid && !m_tuser, m_tdata[63:16] == '0)
  // A mixed frame waiting for queue space is held unchanged.
  `DMEF_ASSERT_NEXT(a_push_hold, push_valid && !push_ready, push_valid && $stable(push_item))

endmodule
